@@ src/css_pkg.sv @@
// Shared types and constants for the context splice, shift and scale block.
package css_pkg;

    // Default sizes of the stores and of the fixed-point format.
    localparam int MAX_FRAMES_DEF      = 1024;
    localparam int MAX_FEATURE_DIM_DEF = 64;
    localparam int MAX_SPLICE_DEF      = 32;
    localparam int FRAC_BITS_DEF       = 16;

    // Field widths of the input and result transactions.
    localparam int CMD_W       = 3;
    localparam int FRAME_W     = 10;
    localparam int SLOT_W      = 5;
    localparam int COL_W       = 6;
    localparam int COEF_IDX_W  = 11;
    localparam int DATA_W      = 32;
    localparam int OFFSET_W    = 5;
    localparam int ROW_OUT_W   = 10;
    localparam int COL_OUT_W   = 11;

    // Configuration register widths.
    localparam int VALID_FRAMES_W = 11;
    localparam int FIRST_ROW_W    = 10;
    localparam int ROW_COUNT_W    = 11;
    localparam int FEATURE_DIM_W  = 7;
    localparam int SPLICE_COUNT_W = 6;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_INDEX_W    = 3;

    // Signed width for the spliced row before clamping; covers a frame index
    // plus offset and a clamp limit of up to 4096 frames.
    localparam int ROW_CALC_W = 14;

    // Configuration reset values.
    localparam logic                      SKIP_MODE_RST    = 1'b0;
    localparam logic [VALID_FRAMES_W-1:0] VALID_FRAMES_RST = 11'd1024;
    localparam logic [FIRST_ROW_W-1:0]    FIRST_ROW_RST    = 10'd0;
    localparam logic [ROW_COUNT_W-1:0]    ROW_COUNT_RST    = 11'd1024;
    localparam logic [FEATURE_DIM_W-1:0]  FEATURE_DIM_RST  = 7'd40;
    localparam logic [SPLICE_COUNT_W-1:0] SPLICE_COUNT_RST = 6'd11;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_WR_FEATURE = 3'd0,
        CMD_WR_OFFSET  = 3'd1,
        CMD_WR_SHIFT   = 3'd2,
        CMD_WR_SCALE   = 3'd3,
        CMD_COMPUTE    = 3'd4
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SKIP_MODE    = 3'd0,
        REG_VALID_FRAMES = 3'd1,
        REG_FIRST_ROW    = 3'd2,
        REG_ROW_COUNT    = 3'd3,
        REG_FEATURE_DIM  = 3'd4,
        REG_SPLICE_COUNT = 3'd5
    } cfg_reg_idx_t;

    typedef struct packed {
        logic                      skip_mode;
        logic [VALID_FRAMES_W-1:0] valid_frames;
        logic [FIRST_ROW_W-1:0]    first_row;
        logic [ROW_COUNT_W-1:0]    row_count;
        logic [FEATURE_DIM_W-1:0]  feature_dim;
        logic [SPLICE_COUNT_W-1:0] splice_count;
    } cfg_t;

    // Store write strobes from the command decoder.
    typedef struct packed {
        logic feat_we;
        logic shift_we;
        logic scale_we;
    } mem_wr_t;

    // Result tag that travels down the pipeline with each column.
    typedef struct packed {
        logic                 error;
        logic                 last;
        logic [ROW_OUT_W-1:0] orow;
        logic [COL_OUT_W-1:0] ocol;
    } tag_t;

endpackage

@@ src/css_seq.sv @@
// Command decoder and column sequencer: takes one transaction, performs store
// writes, checks compute requests and issues one column per cycle on advance.
module css_seq #(
    parameter int MAX_FRAMES      = css_pkg::MAX_FRAMES_DEF,
    parameter int MAX_FEATURE_DIM = css_pkg::MAX_FEATURE_DIM_DEF,
    parameter int MAX_SPLICE      = css_pkg::MAX_SPLICE_DEF,
    localparam int FEAT_AW = $clog2(MAX_FRAMES * MAX_FEATURE_DIM),
    localparam int COEF_AW = $clog2(MAX_SPLICE * MAX_FEATURE_DIM)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  css_pkg::cfg_t                       cfg,
    input  logic                                advance,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [css_pkg::CMD_W-1:0]           cmd,
    input  logic [css_pkg::FRAME_W-1:0]         frame,
    input  logic [css_pkg::SLOT_W-1:0]          slot,
    input  logic [css_pkg::COL_W-1:0]           col,
    input  logic [css_pkg::COEF_IDX_W-1:0]      coef_index,
    input  logic signed [css_pkg::DATA_W-1:0]   data,
    input  logic signed [css_pkg::OFFSET_W-1:0] offset,
    output css_pkg::mem_wr_t                    wr,
    output logic [FEAT_AW-1:0]                  feat_waddr,
    output logic [COEF_AW-1:0]                  coef_waddr,
    output logic [css_pkg::DATA_W-1:0]          wdata,
    output logic                                issue_valid,
    output css_pkg::tag_t                       issue_tag,
    output logic [FEAT_AW-1:0]                  feat_raddr,
    output logic [COEF_AW-1:0]                  coef_raddr
);

    localparam int FEAT_DEPTH = MAX_FRAMES * MAX_FEATURE_DIM;
    localparam int COEF_DEPTH = MAX_SPLICE * MAX_FEATURE_DIM;
    localparam int ROWA_W     = $clog2(MAX_FRAMES);
    localparam int J_W        = $clog2(MAX_FEATURE_DIM);
    localparam int SLOT_AW    = (MAX_SPLICE > 1) ? $clog2(MAX_SPLICE) : 1;
    localparam int ROW_W      = css_pkg::ROW_CALC_W;
    localparam int FD_W       = css_pkg::FEATURE_DIM_W;
    localparam int SC_W       = css_pkg::SPLICE_COUNT_W;
    localparam int FR_W       = css_pkg::FRAME_W;
    localparam int RC_W       = css_pkg::ROW_COUNT_W;
    localparam int RO_W       = css_pkg::ROW_OUT_W;
    localparam int CO_W       = css_pkg::COL_OUT_W;

    logic signed [css_pkg::OFFSET_W-1:0] offset_reg [MAX_SPLICE];

    logic               busy_reg, busy_next;
    logic [J_W-1:0]     j_reg, j_next;
    logic [ROWA_W-1:0]  row_reg, row_next;
    logic [COEF_AW-1:0] base_reg, base_next;
    logic [RO_W-1:0]    orow_reg, orow_next;

    logic                                accept;
    logic                                is_compute;
    logic [FD_W-1:0]                     dim;
    logic [SC_W-1:0]                     slots;
    logic [FR_W-1:0]                     delta;
    logic                                req_err;
    logic signed [css_pkg::OFFSET_W-1:0] offset_rd;
    logic signed [ROW_W-1:0]             rsum;
    logic [ROW_W-1:0]                    lim;
    logic [ROWA_W-1:0]                   row_clamped;
    logic                                last_col;

    // Handshake: one transaction at a time, none while the pipeline holds.
    assign in_stall   = busy_reg || !advance;
    assign accept     = in_valid && !in_stall;
    assign is_compute = (cmd == css_pkg::CMD_COMPUTE);
    assign wdata      = data;

    // Effective dimensions from the configuration.
    assign dim   = (32'(cfg.feature_dim) < MAX_FEATURE_DIM) ? cfg.feature_dim
                                                            : FD_W'(MAX_FEATURE_DIM);
    assign slots = (32'(cfg.splice_count) < MAX_SPLICE) ? cfg.splice_count
                                                        : SC_W'(MAX_SPLICE);
    assign delta = frame - cfg.first_row;

    // A compute request outside the covered range gives one error result.
    assign req_err = (32'(slot) >= 32'(slots)) || (dim == '0) ||
                     (frame < cfg.first_row) || (RC_W'(delta) >= cfg.row_count);

    // Spliced row, clamped into the valid frames.
    assign offset_rd = offset_reg[slot[SLOT_AW-1:0]];

    always_comb
    begin
        rsum = ROW_W'(frame) + ROW_W'(offset_rd);
        lim  = (32'(cfg.valid_frames) < MAX_FRAMES) ? ROW_W'(cfg.valid_frames)
                                                    : ROW_W'(MAX_FRAMES);
        if (lim == '0)
        begin
            lim = ROW_W'(1);
        end
        if (rsum[ROW_W-1])
        begin
            row_clamped = '0;
        end
        else if (ROW_W'(rsum) >= lim)
        begin
            row_clamped = ROWA_W'(lim - ROW_W'(1));
        end
        else
        begin
            row_clamped = ROWA_W'(rsum);
        end
    end

    // Store write decode; writes outside the stores are dropped.
    always_comb
    begin
        wr         = '0;
        feat_waddr = FEAT_AW'(32'(frame) * MAX_FEATURE_DIM + 32'(col));
        coef_waddr = COEF_AW'(coef_index);
        if (accept)
        begin
            unique case (css_pkg::cmd_t'(cmd))
                css_pkg::CMD_WR_FEATURE:
                    wr.feat_we = (32'(frame) < MAX_FRAMES) &&
                                 (32'(col) < MAX_FEATURE_DIM);
                css_pkg::CMD_WR_SHIFT:
                    wr.shift_we = (32'(coef_index) < COEF_DEPTH);
                css_pkg::CMD_WR_SCALE:
                    wr.scale_we = (32'(coef_index) < COEF_DEPTH);
                default:
                    wr = '0;
            endcase
        end
    end

    // Column issue: read addresses and result tag for the current column.
    assign last_col   = ((FD_W'(j_reg) + FD_W'(1)) == dim);
    assign coef_raddr = base_reg + COEF_AW'(j_reg);
    assign feat_raddr = FEAT_AW'(32'(row_reg) * MAX_FEATURE_DIM + 32'(j_reg));

    always_comb
    begin
        issue_valid = busy_reg || (accept && is_compute && req_err);
        if (busy_reg)
        begin
            issue_tag.error = 1'b0;
            issue_tag.last  = last_col;
            issue_tag.orow  = orow_reg;
            issue_tag.ocol  = CO_W'(coef_raddr);
        end
        else
        begin
            issue_tag.error = 1'b1;
            issue_tag.last  = 1'b1;
            issue_tag.orow  = '0;
            issue_tag.ocol  = '0;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        busy_next = busy_reg;
        j_next    = j_reg;
        row_next  = row_reg;
        base_next = base_reg;
        orow_next = orow_reg;
        if (accept && is_compute && !req_err)
        begin
            busy_next = 1'b1;
            j_next    = '0;
            row_next  = row_clamped;
            base_next = COEF_AW'(32'(slot) * 32'(dim));
            orow_next = cfg.skip_mode ? RO_W'(delta >> 1) : RO_W'(delta);
        end
        else if (busy_reg && advance)
        begin
            if (last_col)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                j_next = j_reg + J_W'(1);
            end
        end
    end

    // Control state and the offset table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            j_reg    <= '0;
            for (int i = 0; i < MAX_SPLICE; i++)
            begin
                offset_reg[i] <= '0;
            end
        end
        else
        begin
            busy_reg <= busy_next;
            j_reg    <= j_next;
            if (accept && (cmd == css_pkg::CMD_WR_OFFSET) && (32'(slot) < MAX_SPLICE))
            begin
                offset_reg[slot[SLOT_AW-1:0]] <= offset;
            end
        end
    end

    // Request payload.
    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        base_reg <= base_next;
        orow_reg <= orow_next;
    end

    a_busy_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && advance && last_col) |=> !busy_reg)
        else $error("sequencer stayed busy after the last column");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (FD_W'(j_reg) < dim))
        else $error("column counter ran past the feature dimension");

endmodule

@@ src/css_mem.sv @@
// Feature store and coefficient tables with registered reads; the read
// register forms the first pipeline stage together with the result tag.
module css_mem #(
    parameter int MAX_FRAMES      = css_pkg::MAX_FRAMES_DEF,
    parameter int MAX_FEATURE_DIM = css_pkg::MAX_FEATURE_DIM_DEF,
    parameter int MAX_SPLICE      = css_pkg::MAX_SPLICE_DEF,
    localparam int FEAT_AW = $clog2(MAX_FRAMES * MAX_FEATURE_DIM),
    localparam int COEF_AW = $clog2(MAX_SPLICE * MAX_FEATURE_DIM)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  css_pkg::mem_wr_t           wr,
    input  logic [FEAT_AW-1:0]         feat_waddr,
    input  logic [COEF_AW-1:0]         coef_waddr,
    input  logic [css_pkg::DATA_W-1:0] wdata,
    input  logic                       issue_valid,
    input  css_pkg::tag_t              issue_tag,
    input  logic [FEAT_AW-1:0]         feat_raddr,
    input  logic [COEF_AW-1:0]         coef_raddr,
    output logic                       s1_valid,
    output css_pkg::tag_t              s1_tag,
    output logic [css_pkg::DATA_W-1:0] s1_feat,
    output logic [css_pkg::DATA_W-1:0] s1_shift,
    output logic [css_pkg::DATA_W-1:0] s1_scale
);

    localparam int FEAT_DEPTH = MAX_FRAMES * MAX_FEATURE_DIM;
    localparam int COEF_DEPTH = MAX_SPLICE * MAX_FEATURE_DIM;
    localparam int DW         = css_pkg::DATA_W;

    logic [DW-1:0] feat_mem  [FEAT_DEPTH];
    logic [DW-1:0] shift_mem [COEF_DEPTH];
    logic [DW-1:0] scale_mem [COEF_DEPTH];

    logic          s1_valid_reg;
    css_pkg::tag_t s1_tag_reg;
    logic [DW-1:0] s1_feat_reg;
    logic [DW-1:0] s1_shift_reg;
    logic [DW-1:0] s1_scale_reg;

    // Feature store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.feat_we)
        begin
            feat_mem[feat_waddr] <= wdata;
        end
        if (advance)
        begin
            s1_feat_reg <= feat_mem[feat_raddr];
        end
    end

    // Shift table.
    always_ff @(posedge clk)
    begin
        if (wr.shift_we)
        begin
            shift_mem[coef_waddr] <= wdata;
        end
        if (advance)
        begin
            s1_shift_reg <= shift_mem[coef_raddr];
        end
    end

    // Scale table.
    always_ff @(posedge clk)
    begin
        if (wr.scale_we)
        begin
            scale_mem[coef_waddr] <= wdata;
        end
        if (advance)
        begin
            s1_scale_reg <= scale_mem[coef_raddr];
        end
    end

    // Stage one valid bit and tag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= issue_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_tag_reg <= issue_tag;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_tag   = s1_tag_reg;
    assign s1_feat  = s1_feat_reg;
    assign s1_shift = s1_shift_reg;
    assign s1_scale = s1_scale_reg;

endmodule

@@ src/css_arith.sv @@
// Arithmetic stages: saturating add, multiply, round and saturate into the
// output register.
module css_arith #(
    parameter int FRAC_BITS = css_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 s1_valid,
    input  css_pkg::tag_t                        s1_tag,
    input  logic [css_pkg::DATA_W-1:0]           s1_feat,
    input  logic [css_pkg::DATA_W-1:0]           s1_shift,
    input  logic [css_pkg::DATA_W-1:0]           s1_scale,
    output logic                                 out_valid,
    output logic [css_pkg::ROW_OUT_W-1:0]        out_row,
    output logic [css_pkg::COL_OUT_W-1:0]        out_col,
    output logic signed [css_pkg::DATA_W-1:0]    value,
    output logic                                 last,
    output logic                                 error
);

    localparam int DW = css_pkg::DATA_W;
    localparam int PW = 2 * DW;
    localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [PW-1:0] HALF    = PW'(1) << (FRAC_BITS - 1);

    logic                 s2_valid_reg, s3_valid_reg, out_valid_reg;
    css_pkg::tag_t        s2_tag_reg, s3_tag_reg, out_tag_reg;
    logic signed [DW-1:0] s2_sum_reg, s2_sum_next;
    logic signed [DW-1:0] s2_scale_reg;
    logic signed [PW-1:0] s3_prod_reg, s3_prod_next;
    logic signed [DW-1:0] value_reg, value_next;

    logic signed [DW:0]   sum_wide;
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] shifted;

    // Stage two: feature plus shift, saturated to the data width.
    always_comb
    begin
        sum_wide = $signed({s1_feat[DW-1], s1_feat}) + $signed({s1_shift[DW-1], s1_shift});
        if (sum_wide[DW] != sum_wide[DW-1])
        begin
            s2_sum_next = sum_wide[DW] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            s2_sum_next = sum_wide[DW-1:0];
        end
    end

    // Stage three: full-width signed product.
    assign s3_prod_next = PW'(s2_sum_reg) * PW'(s2_scale_reg);

    // Output stage: round half up at binary point, saturate; zero on error.
    always_comb
    begin
        rnd     = s3_prod_reg + HALF;
        shifted = rnd >>> FRAC_BITS;
        if (shifted > PW'(SAT_MAX))
        begin
            value_next = SAT_MAX;
        end
        else if (shifted < PW'(SAT_MIN))
        begin
            value_next = SAT_MIN;
        end
        else
        begin
            value_next = shifted[DW-1:0];
        end
        if (s3_tag_reg.error)
        begin
            value_next = '0;
        end
    end

    // Valid bits move with the data on every advance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= s1_valid;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_tag_reg   <= s1_tag;
            s2_sum_reg   <= s2_sum_next;
            s2_scale_reg <= s1_scale;
            s3_tag_reg   <= s2_tag_reg;
            s3_prod_reg  <= s3_prod_next;
            out_tag_reg  <= s3_tag_reg;
            value_reg    <= value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_tag_reg.orow;
    assign out_col   = out_tag_reg.ocol;
    assign value     = value_reg;
    assign last      = out_tag_reg.last;
    assign error     = out_tag_reg.error;

    a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && advance) |=> out_valid_reg)
        else $error("result lost between the product and output stages");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_tag_reg.error) |-> ((value_reg == '0) && out_tag_reg.last))
        else $error("error result carries a value or is not marked last");

endmodule

@@ src/context_splice_shift_scale.sv @@
// Speech-feature front end: write transactions load the feature store, the
// splice offsets and the per-column shift and scale tables. A compute
// transaction issues feature_dim columns, one per cycle while the output is
// not stalled, as the feature store and coefficient tables each have a single
// read port; it holds the input until its last column is issued. A request
// outside the covered range yields a single error result. Each column passes
// a four-stage pipeline (table read, saturating add, multiply, round and
// saturate). A stall at the output freezes the whole pipeline and the input.
// The feature, shift and scale stores come up unwritten and have no clearing
// pass; the block accepts input right after reset. Configuration must be
// written only while no transaction is in flight; the block itself does not
// enforce it.
module context_splice_shift_scale #(
    parameter int MAX_FRAMES      = css_pkg::MAX_FRAMES_DEF,
    parameter int MAX_FEATURE_DIM = css_pkg::MAX_FEATURE_DIM_DEF,
    parameter int MAX_SPLICE      = css_pkg::MAX_SPLICE_DEF,
    parameter int FRAC_BITS       = css_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [css_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [css_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [css_pkg::CMD_W-1:0]            cmd,
    input  logic [css_pkg::FRAME_W-1:0]          frame,
    input  logic [css_pkg::SLOT_W-1:0]           slot,
    input  logic [css_pkg::COL_W-1:0]            col,
    input  logic [css_pkg::COEF_IDX_W-1:0]       coef_index,
    input  logic signed [css_pkg::DATA_W-1:0]    data,
    input  logic signed [css_pkg::OFFSET_W-1:0]  offset,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [css_pkg::ROW_OUT_W-1:0]        out_row,
    output logic [css_pkg::COL_OUT_W-1:0]        out_col,
    output logic signed [css_pkg::DATA_W-1:0]    value,
    output logic                                 last,
    output logic                                 error
);

    localparam int FEAT_AW = $clog2(MAX_FRAMES * MAX_FEATURE_DIM);
    localparam int COEF_AW = $clog2(MAX_SPLICE * MAX_FEATURE_DIM);
    localparam int DW      = css_pkg::DATA_W;

    css_pkg::cfg_t cfg_reg, cfg_next;

    logic                advance;
    css_pkg::mem_wr_t    wr;
    logic [FEAT_AW-1:0]  feat_waddr, feat_raddr;
    logic [COEF_AW-1:0]  coef_waddr, coef_raddr;
    logic [DW-1:0]       wdata;
    logic                issue_valid;
    css_pkg::tag_t       issue_tag;
    logic                s1_valid;
    css_pkg::tag_t       s1_tag;
    logic [DW-1:0]       s1_feat, s1_shift, s1_scale;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (css_pkg::cfg_reg_idx_t'(cfg_index))
                css_pkg::REG_SKIP_MODE:
                    cfg_next.skip_mode = cfg_data[0];
                css_pkg::REG_VALID_FRAMES:
                    cfg_next.valid_frames = cfg_data[css_pkg::VALID_FRAMES_W-1:0];
                css_pkg::REG_FIRST_ROW:
                    cfg_next.first_row = cfg_data[css_pkg::FIRST_ROW_W-1:0];
                css_pkg::REG_ROW_COUNT:
                    cfg_next.row_count = cfg_data[css_pkg::ROW_COUNT_W-1:0];
                css_pkg::REG_FEATURE_DIM:
                    cfg_next.feature_dim = cfg_data[css_pkg::FEATURE_DIM_W-1:0];
                css_pkg::REG_SPLICE_COUNT:
                    cfg_next.splice_count = cfg_data[css_pkg::SPLICE_COUNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.skip_mode    <= css_pkg::SKIP_MODE_RST;
            cfg_reg.valid_frames <= css_pkg::VALID_FRAMES_RST;
            cfg_reg.first_row    <= css_pkg::FIRST_ROW_RST;
            cfg_reg.row_count    <= css_pkg::ROW_COUNT_RST;
            cfg_reg.feature_dim  <= css_pkg::FEATURE_DIM_RST;
            cfg_reg.splice_count <= css_pkg::SPLICE_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The pipeline moves unless a finished result is held at the output.
    assign advance = !(out_valid && out_stall);

    css_seq #(
        .MAX_FRAMES      (MAX_FRAMES),
        .MAX_FEATURE_DIM (MAX_FEATURE_DIM),
        .MAX_SPLICE      (MAX_SPLICE)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .advance     (advance),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .frame       (frame),
        .slot        (slot),
        .col         (col),
        .coef_index  (coef_index),
        .data        (data),
        .offset      (offset),
        .wr          (wr),
        .feat_waddr  (feat_waddr),
        .coef_waddr  (coef_waddr),
        .wdata       (wdata),
        .issue_valid (issue_valid),
        .issue_tag   (issue_tag),
        .feat_raddr  (feat_raddr),
        .coef_raddr  (coef_raddr)
    );

    css_mem #(
        .MAX_FRAMES      (MAX_FRAMES),
        .MAX_FEATURE_DIM (MAX_FEATURE_DIM),
        .MAX_SPLICE      (MAX_SPLICE)
    ) u_mem (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .wr          (wr),
        .feat_waddr  (feat_waddr),
        .coef_waddr  (coef_waddr),
        .wdata       (wdata),
        .issue_valid (issue_valid),
        .issue_tag   (issue_tag),
        .feat_raddr  (feat_raddr),
        .coef_raddr  (coef_raddr),
        .s1_valid    (s1_valid),
        .s1_tag      (s1_tag),
        .s1_feat     (s1_feat),
        .s1_shift    (s1_shift),
        .s1_scale    (s1_scale)
    );

    css_arith #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .s1_valid  (s1_valid),
        .s1_tag    (s1_tag),
        .s1_feat   (s1_feat),
        .s1_shift  (s1_shift),
        .s1_scale  (s1_scale),
        .out_valid (out_valid),
        .out_row   (out_row),
        .out_col   (out_col),
        .value     (value),
        .last      (last),
        .error     (error)
    );

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while the pipeline is frozen");

endmodule
